// File: rtl/core/apgr_pkg.sv
// Package for the armor pixel gradient recolour block: beat types, register
// codes and the Q0.16 ramp constants. No dependencies.
package apgr_pkg;

  // Widths
  localparam int CHAN_W = 8;
  localparam int T_W    = 17;
  localparam int PROD_W = 25;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int NCHAN  = 3;

  // Channel lane order
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_BODY_RED     = 3'd0;
  localparam logic [2:0] REG_BODY_GREEN   = 3'd1;
  localparam logic [2:0] REG_BODY_BLUE    = 3'd2;
  localparam logic [2:0] REG_ACCENT_RED   = 3'd3;
  localparam logic [2:0] REG_ACCENT_GREEN = 3'd4;
  localparam logic [2:0] REG_ACCENT_BLUE  = 3'd5;

  // Classification thresholds
  localparam logic [7:0] BLUE_MIN   = 8'd72;
  localparam logic [8:0] RB_GAP     = 9'd24;
  localparam logic [8:0] RG_SLACK   = 9'd12;
  localparam logic [7:0] SPREAD_MIN = 8'd32;

  // Ramp constants, Q0.16
  localparam logic [16:0] ONE_Q16         = 17'd65536;
  localparam logic [15:0] SHADOW_Q16      = 16'd36045;
  localparam logic [9:0]  LOW_SLOPE_Q16   = 10'd612;
  localparam logic [9:0]  HIGH_SLOPE_Q16  = 10'd988;
  localparam logic [16:0] HIGH_OFFSET_Q16 = 17'd105866;
  localparam logic [7:0]  LOW_LIMIT       = 8'd107;
  localparam logic [7:0]  HIGH_LIMIT      = 8'd173;

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
    logic [CHAN_W-1:0] pixel_alpha;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              recolored;
  } result_t;

  // Colours handed from the register file to the datapath, lane 0 is red
  typedef struct packed {
    logic [NCHAN-1:0][CHAN_W-1:0] body;
    logic [NCHAN-1:0][CHAN_W-1:0] accent;
    logic [NCHAN-1:0][CHAN_W-1:0] shadow;
  } cfg_t;

endpackage

// File: rtl/core/apgr_regs.sv
// APB register file for the recolour block: body and accent colours, plus a
// registered shadow colour (body * 0.55). Depends on apgr_pkg.
module apgr_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apgr_pkg::ADDR_W-1:0]   paddr,
  input  logic [apgr_pkg::DATA_W-1:0]   pwdata,
  output logic [apgr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output apgr_pkg::cfg_t                cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;
  logic [apgr_pkg::NCHAN-1:0][apgr_pkg::CHAN_W-1:0] body;
  logic [apgr_pkg::NCHAN-1:0][apgr_pkg::CHAN_W-1:0] accent;
  logic [apgr_pkg::NCHAN-1:0][apgr_pkg::CHAN_W-1:0] shadow;
  logic [apgr_pkg::NCHAN-1:0][23:0] shadow_prod;

  assign reg_idx = paddr[apgr_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  // Write colour registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      body   <= '0;
      accent <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        apgr_pkg::REG_BODY_RED:     body[apgr_pkg::CH_RED]     <= pwdata[7:0];
        apgr_pkg::REG_BODY_GREEN:   body[apgr_pkg::CH_GREEN]   <= pwdata[7:0];
        apgr_pkg::REG_BODY_BLUE:    body[apgr_pkg::CH_BLUE]    <= pwdata[7:0];
        apgr_pkg::REG_ACCENT_RED:   accent[apgr_pkg::CH_RED]   <= pwdata[7:0];
        apgr_pkg::REG_ACCENT_GREEN: accent[apgr_pkg::CH_GREEN] <= pwdata[7:0];
        apgr_pkg::REG_ACCENT_BLUE:  accent[apgr_pkg::CH_BLUE]  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Shadow colour: truncated body * 0.55, registered so it follows the body in the next cycle
  always_comb begin
    for (int i = 0; i < apgr_pkg::NCHAN; i++) begin
      shadow_prod[i] = 24'(body[i]) * 24'(apgr_pkg::SHADOW_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow <= '0;
    end else begin
      for (int i = 0; i < apgr_pkg::NCHAN; i++) begin
        shadow[i] <= shadow_prod[i][23:16];
      end
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      apgr_pkg::REG_BODY_RED:     prdata = 32'(body[apgr_pkg::CH_RED]);
      apgr_pkg::REG_BODY_GREEN:   prdata = 32'(body[apgr_pkg::CH_GREEN]);
      apgr_pkg::REG_BODY_BLUE:    prdata = 32'(body[apgr_pkg::CH_BLUE]);
      apgr_pkg::REG_ACCENT_RED:   prdata = 32'(accent[apgr_pkg::CH_RED]);
      apgr_pkg::REG_ACCENT_GREEN: prdata = 32'(accent[apgr_pkg::CH_GREEN]);
      apgr_pkg::REG_ACCENT_BLUE:  prdata = 32'(accent[apgr_pkg::CH_BLUE]);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.body   = body;
  assign cfg.accent = accent;
  assign cfg.shadow = shadow;

endmodule

// File: rtl/core/armor_pixel_gradient_recolor.sv
// Armor pixel gradient recolour: classifies each pixel and remaps armor pixels
// onto a shadow/body/accent ramp. Depends on apgr_pkg and apgr_regs.
// Pipeline: five register stages (capture, classify, ramp position, blend
// products, sum). An accepted pixel passes s0, s1, s2 and s3, then done and
// the result beat are registered together. Throughput: one pixel per clock, busy
// stays low outside reset. Reset: synchronous, clears valid bits and colours.
// The receiver cannot stall, so results leave on done without backpressure.
module armor_pixel_gradient_recolor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apgr_pkg::ADDR_W-1:0]   paddr,
  input  logic [apgr_pkg::DATA_W-1:0]   pwdata,
  output logic [apgr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  apgr_pkg::pixel_t              pixel,
  output logic                          done,
  output apgr_pkg::result_t             result
);

  localparam int NCH = apgr_pkg::NCHAN;
  localparam int CW  = apgr_pkg::CHAN_W;

  apgr_pkg::cfg_t cfg;

  apgr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy = rst;

  // Stage 0: capture the beat
  logic             s0_valid;
  apgr_pkg::pixel_t s0_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_pix <= pixel;
  end

  // Stage 1: classify and find the brightest channel
  logic [CW-1:0] c_max, c_min, c_rg_max, c_rg_min;
  logic          c_armor;

  always_comb begin
    c_rg_max = (s0_pix.pixel_green > s0_pix.pixel_red) ? s0_pix.pixel_green : s0_pix.pixel_red;
    c_rg_min = (s0_pix.pixel_green < s0_pix.pixel_red) ? s0_pix.pixel_green : s0_pix.pixel_red;
    c_max    = (s0_pix.pixel_blue > c_rg_max) ? s0_pix.pixel_blue : c_rg_max;
    c_min    = (s0_pix.pixel_blue < c_rg_min) ? s0_pix.pixel_blue : c_rg_min;
    c_armor  = (s0_pix.pixel_alpha != '0)
            && (s0_pix.pixel_blue >= apgr_pkg::BLUE_MIN)
            && ({1'b0, s0_pix.pixel_blue} >= ({1'b0, s0_pix.pixel_red} + apgr_pkg::RB_GAP))
            && (({1'b0, s0_pix.pixel_green} + apgr_pkg::RG_SLACK) >= {1'b0, s0_pix.pixel_red})
            && ((c_max - c_min) >= apgr_pkg::SPREAD_MIN);
  end

  logic             s1_valid;
  apgr_pkg::pixel_t s1_pix;
  logic             s1_armor;
  logic [CW-1:0]    s1_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix   <= s0_pix;
    s1_armor <= c_armor;
    s1_max   <= c_max;
  end

  // Stage 2: ramp position t and the two end colours of the segment
  logic [17:0]                  lo_prod, hi_prod, hi_diff;
  logic [apgr_pkg::T_W-1:0]     t_next;
  logic [NCH-1:0][CW-1:0]       lo_next, hi_next;

  always_comb begin
    lo_prod = 18'(s1_max) * 18'(apgr_pkg::LOW_SLOPE_Q16);
    hi_prod = 18'(s1_max) * 18'(apgr_pkg::HIGH_SLOPE_Q16);
    hi_diff = hi_prod - 18'(apgr_pkg::HIGH_OFFSET_Q16);
    if (s1_max <= apgr_pkg::LOW_LIMIT) begin
      t_next  = lo_prod[apgr_pkg::T_W-1:0];
      lo_next = cfg.shadow;
      hi_next = cfg.body;
    end else if (s1_max <= apgr_pkg::HIGH_LIMIT) begin
      t_next  = hi_diff[apgr_pkg::T_W-1:0];
      lo_next = cfg.body;
      hi_next = cfg.accent;
    end else begin
      t_next  = apgr_pkg::ONE_Q16;
      lo_next = cfg.body;
      hi_next = cfg.accent;
    end
  end

  logic                     s2_valid;
  apgr_pkg::pixel_t         s2_pix;
  logic                     s2_armor;
  logic [apgr_pkg::T_W-1:0] s2_t;
  logic [NCH-1:0][CW-1:0]   s2_lo, s2_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_pix   <= s1_pix;
    s2_armor <= s1_armor;
    s2_t     <= t_next;
    s2_lo    <= lo_next;
    s2_hi    <= hi_next;
  end

  // Stage 3: weight each end colour per lane
  logic [NCH-1:0][apgr_pkg::PROD_W-1:0] pa_next, pb_next;
  logic [apgr_pkg::T_W-1:0]             t_inv;

  always_comb begin
    t_inv = apgr_pkg::ONE_Q16 - s2_t;
    for (int i = 0; i < NCH; i++) begin
      pa_next[i] = apgr_pkg::PROD_W'(s2_lo[i]) * apgr_pkg::PROD_W'(t_inv);
      pb_next[i] = apgr_pkg::PROD_W'(s2_hi[i]) * apgr_pkg::PROD_W'(s2_t);
    end
  end

  logic                                 s3_valid;
  apgr_pkg::pixel_t                     s3_pix;
  logic                                 s3_armor;
  logic [NCH-1:0][apgr_pkg::PROD_W-1:0] s3_pa, s3_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_pix   <= s2_pix;
    s3_armor <= s2_armor;
    s3_pa    <= pa_next;
    s3_pb    <= pb_next;
  end

  // Stage 4: sum, drop the fraction and pick armor or pass-through
  logic [NCH-1:0][apgr_pkg::PROD_W:0] blend_sum;
  apgr_pkg::result_t                  result_next;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      blend_sum[i] = (apgr_pkg::PROD_W + 1)'(s3_pa[i]) + (apgr_pkg::PROD_W + 1)'(s3_pb[i]);
    end
    result_next.out_alpha = s3_pix.pixel_alpha;
    result_next.recolored = s3_armor;
    if (s3_armor) begin
      result_next.out_red   = blend_sum[apgr_pkg::CH_RED][23:16];
      result_next.out_green = blend_sum[apgr_pkg::CH_GREEN][23:16];
      result_next.out_blue  = blend_sum[apgr_pkg::CH_BLUE][23:16];
    end else begin
      result_next.out_red   = s3_pix.pixel_red;
      result_next.out_green = s3_pix.pixel_green;
      result_next.out_blue  = s3_pix.pixel_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Checks
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result beat without a matching accepted pixel");

  a_recolor_needs_alpha: assert property (@(posedge clk) disable iff (rst)
    done && result.recolored |-> result.out_alpha != '0)
    else $error("transparent pixel was recoloured");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    done && !result.recolored |-> result.out_red == $past(pixel.pixel_red, 5)
      && result.out_blue == $past(pixel.pixel_blue, 5))
    else $error("pass-through pixel altered");

endmodule

// File: sim/tb_armor_pixel_gradient_recolor.sv
// Testbench for armor_pixel_gradient_recolor: drives pixels and APB colour writes,
// predicts each result independently and checks it beat by beat.
// Depends on apgr_pkg and the RTL of the block only.
module tb_armor_pixel_gradient_recolor;
  import apgr_pkg::*;

  // Classification thresholds and Q0.16 ramp constants
  localparam int ARMOR_BLUE_FLOOR = 72;
  localparam int ARMOR_RB_GAP     = 24;
  localparam int ARMOR_RG_SLACK   = 12;
  localparam int ARMOR_SPREAD     = 32;
  localparam int DARK_KNEE        = 107;
  localparam int BRIGHT_KNEE      = 173;
  localparam longint unsigned UNITY_Q16     = 65536;
  localparam longint unsigned SHADE_Q16     = 36045;
  localparam longint unsigned SLOPE_DARK    = 612;
  localparam longint unsigned SLOPE_BRIGHT  = 988;
  localparam longint unsigned BRIGHT_OFFSET = 105866;

  // Register slots with no register behind them
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  class recolor_scoreboard;
    logic [7:0] body_col [NCHAN];
    logic [7:0] accent_col [NCHAN];
    result_t    expected_pixels [$];
    int         errors = 0;
    int         pixels_seen = 0;
    int         pixels_recoloured = 0;

    function void set_register(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_BODY_RED:     body_col[CH_RED]     = val;
        REG_BODY_GREEN:   body_col[CH_GREEN]   = val;
        REG_BODY_BLUE:    body_col[CH_BLUE]    = val;
        REG_ACCENT_RED:   accent_col[CH_RED]   = val;
        REG_ACCENT_GREEN: accent_col[CH_GREEN] = val;
        REG_ACCENT_BLUE:  accent_col[CH_BLUE]  = val;
        default: ;
      endcase
    endfunction

    function int unsigned mix_q16(longint unsigned from_c, longint unsigned to_c,
                                  longint unsigned t);
      longint unsigned v;
      if (t > UNITY_Q16) t = UNITY_Q16;
      v = (from_c * (UNITY_Q16 - t) + to_c * t) >> 16;
      return (v > 255) ? 255 : int'(v);
    endfunction

    function result_t recolor_pixel(pixel_t p);
      int r, g, b, hi, lo;
      bit armor;
      longint unsigned t, shade;
      int unsigned chan [NCHAN];
      result_t res;
      r = p.pixel_red;
      g = p.pixel_green;
      b = p.pixel_blue;
      hi = r; lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      armor = (p.pixel_alpha != 0) && (b >= ARMOR_BLUE_FLOOR) && (b >= r + ARMOR_RB_GAP)
              && (g >= r - ARMOR_RG_SLACK) && (hi - lo >= ARMOR_SPREAD);
      res.out_alpha = p.pixel_alpha;
      res.recolored = armor;
      if (!armor) begin
        res.out_red   = p.pixel_red;
        res.out_green = p.pixel_green;
        res.out_blue  = p.pixel_blue;
        return res;
      end
      for (int ch = 0; ch < NCHAN; ch++) begin
        if (hi <= DARK_KNEE) begin
          // shadow towards body
          t = longint'(hi) * SLOPE_DARK;
          shade = (longint'(body_col[ch]) * SHADE_Q16) >> 16;
          if (shade > 255) shade = 255;
          chan[ch] = mix_q16(shade, body_col[ch], t);
        end else if (hi <= BRIGHT_KNEE) begin
          // body towards accent
          t = longint'(hi) * SLOPE_BRIGHT;
          t = (t > BRIGHT_OFFSET) ? t - BRIGHT_OFFSET : 0;
          chan[ch] = mix_q16(body_col[ch], accent_col[ch], t);
        end else begin
          chan[ch] = accent_col[ch];
        end
      end
      res.out_red   = 8'(chan[CH_RED]);
      res.out_green = 8'(chan[CH_GREEN]);
      res.out_blue  = 8'(chan[CH_BLUE]);
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      result_t want;
      want = recolor_pixel(p);
      expected_pixels.push_back(want);
      pixels_seen++;
      if (want.recolored) pixels_recoloured++;
    endfunction

    // Four-state compare so an unknown output bit counts as a mismatch
    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, got %h", $time, got);
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("out_red",   want.out_red,   got.out_red);
      compare_field("out_green", want.out_green, got.out_green);
      compare_field("out_blue",  want.out_blue,  got.out_blue);
      compare_field("out_alpha", want.out_alpha, got.out_alpha);
      compare_field("recolored", 8'(want.recolored), 8'(got.recolored));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic start;
  logic busy;
  pixel_t pixel;
  logic done;
  result_t result;

  recolor_scoreboard sb = new();
  int gap_pct = 0;
  int colour_settings = 0;

  armor_pixel_gradient_recolor dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Check every result beat at the edge that ends it
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(result);
  end

  // APB write: setup then access, register taken when pready is high
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_W'({idx, 2'b00});
    pwdata = DATA_W'(val);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_colours(input logic [7:0] br, input logic [7:0] bg, input logic [7:0] bb,
                             input logic [7:0] ar, input logic [7:0] ag, input logic [7:0] ab);
    write_reg(REG_BODY_RED, br);
    write_reg(REG_BODY_GREEN, bg);
    write_reg(REG_BODY_BLUE, bb);
    write_reg(REG_ACCENT_RED, ar);
    write_reg(REG_ACCENT_GREEN, ag);
    write_reg(REG_ACCENT_BLUE, ab);
    colour_settings++;
  endtask

  // Offer one pixel after a random gap, hold it until accepted
  task automatic send_pixel(input pixel_t p);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start = 1'b0;
      pixel = pixel_t'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    pixel = p;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly armor-shaped pixels across the whole ramp, some near the
  // classification edges, the rest raw noise
  task automatic run_random_phase(input int count, input int pct);
    int r, g, b, a, m, kind;
    pixel_t p;
    gap_pct = pct;
    repeat (count) begin
      kind = $urandom_range(99);
      a = ($urandom_range(19) == 0) ? 0 : $urandom_range(255, 1);
      if (kind < 55) begin
        m = $urandom_range(255, ARMOR_BLUE_FLOOR);
        b = m;
        r = $urandom_range(m - ARMOR_RB_GAP, 0);
        g = $urandom_range(m, (r >= ARMOR_RG_SLACK) ? r - ARMOR_RG_SLACK : 0);
        if ($urandom_range(3) == 0) g = $urandom_range(255, 0);
        p = {8'(r), 8'(g), 8'(b), 8'(a)};
      end else if (kind < 70) begin
        r = $urandom_range(231, 0);
        b = r + ARMOR_RB_GAP - 1 + $urandom_range(1, 0);
        g = r - ARMOR_RG_SLACK - 1 + $urandom_range(40, 0);
        if (g < 0) g = 0;
        if (g > 255) g = 255;
        p = {8'(r), 8'(g), 8'(b), 8'(a)};
      end else begin
        p = pixel_t'($urandom);
      end
      send_pixel(p);
    end
    start = 1'b0;
    gap_pct = 0;
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    pixel = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: mid colours, spare slots written and expected to be ignored
    set_colours(8'd200, 8'd150, 8'd100, 8'd30, 8'd240, 8'd90);
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'hA5);
    send_pixel({8'd0,   8'd0,   8'd0,   8'd0});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel({8'd0,   8'd0,   8'd72,  8'd255});   // dimmest armor
    send_pixel({8'd0,   8'd0,   8'd71,  8'd255});   // blue just too low
    send_pixel({8'd20,  8'd30,  8'd107, 8'd200});   // top of shadow ramp
    send_pixel({8'd20,  8'd30,  8'd108, 8'd200});   // start of accent ramp
    send_pixel({8'd20,  8'd30,  8'd173, 8'd1});
    send_pixel({8'd20,  8'd30,  8'd174, 8'd128});   // flat accent
    send_pixel({8'd0,   8'd255, 8'd255, 8'd255});
    send_pixel({8'd40,  8'd40,  8'd72,  8'd255});   // spread exactly enough
    send_pixel({8'd41,  8'd41,  8'd72,  8'd255});   // spread one short
    send_pixel({8'd60,  8'd100, 8'd84,  8'd255});   // blue exactly red plus gap
    send_pixel({8'd61,  8'd100, 8'd84,  8'd255});
    send_pixel({8'd50,  8'd38,  8'd120, 8'd255});   // green exactly red minus slack
    send_pixel({8'd50,  8'd37,  8'd120, 8'd255});
    send_pixel({8'd5,   8'd0,   8'd100, 8'd255});   // red minus slack below zero
    send_pixel({8'd0,   8'd0,   8'd200, 8'd0});     // transparent, left alone
    send_pixel({8'd255, 8'd0,   8'd0,   8'd255});
    send_pixel({8'd100, 8'd200, 8'd150, 8'd77});    // green is the brightest
    send_pixel({8'd10,  8'd90,  8'd100, 8'd255});
    send_pixel({8'd170, 8'd255, 8'd255, 8'd255});
    start = 1'b0;
    wait_drained();

    // Random phases over extreme and random colour settings
    set_colours(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    run_random_phase(110, 0);
    set_colours(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    run_random_phase(110, 73);
    set_colours(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random_phase(110, 24);
    set_colours(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random_phase(110, 73);
    set_colours(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random_phase(110, 0);

    // Let any stray result show up before judging
    repeat (10) @(posedge clk);
    $display("Checked %0d pixels (%0d recoloured) over %0d colour settings,",
             sb.pixels_seen, sb.pixels_recoloured, colour_settings);
    $display("with sender gaps of none, 24 and 73 in a hundred; spare slots written.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #600000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
